### hw/rtl/pidc_pkg.sv
package pidc_pkg;

   // Field and register widths
   localparam int DATA_W   = 32;
   localparam int LIMIT_W  = 31;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W   = 4;

   // Divider: dividend is |error delta| shifted up by 16, one quotient bit a cycle
   localparam int DIV_DIVIDEND_W = 48;
   localparam int DIV_STEPS      = DIV_DIVIDEND_W;
   localparam int DIV_CNT_W      = 6;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND     = 3'd5;

   // Register reset values
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'h7fffffff;
   localparam logic [LIMIT_W-1:0] BAND_RESET  = 31'd3277;

   // Saturation bounds for 32-bit signed results
   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fffffff;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h80000000;

   // Program steps
   localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ERR      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DIFF     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_INTEG    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_ACC_P    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_ACC_I    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DIV_WAIT = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DER      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MUL_D    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ACC_D    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd10;

   // Branch condition: hold at the current step while true, else go to next_step
   typedef enum logic [1:0] {
      COND_NEXT,
      COND_WAIT_REQ,
      COND_WAIT_DIV,
      COND_WAIT_OUT
   } cond_type;

   // Operand pair for the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_ERR_DT,
      MUL_KP_ERR,
      MUL_KI_INT,
      MUL_KD_DER
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // One control word
   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] next_step;
      logic              err_en;
      logic              div_start;
      logic              prev_en;
      logic              integ_en;
      logic              der_en;
      logic              emit;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
   } ucode_type;

   // Divider control and status
   typedef struct packed {
      logic                      start;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DATA_W-1:0]         divisor;
   } div_req_type;

   typedef struct packed {
      logic                      busy;
      logic [DIV_DIVIDEND_W-1:0] quotient;
   } div_stat_type;

   // Program store
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      w.cond    = COND_NEXT;
      w.mul_sel = MUL_NONE;
      w.acc_op  = ACC_HOLD;
      case (step)
         STEP_WAIT: begin
            w.cond      = COND_WAIT_REQ;
            w.next_step = STEP_ERR;
         end
         STEP_ERR: begin
            w.err_en    = 1'b1;
            w.next_step = STEP_DIFF;
         end
         STEP_DIFF: begin
            w.div_start = 1'b1;
            w.prev_en   = 1'b1;
            w.mul_sel   = MUL_ERR_DT;
            w.next_step = STEP_INTEG;
         end
         STEP_INTEG: begin
            w.integ_en  = 1'b1;
            w.mul_sel   = MUL_KP_ERR;
            w.next_step = STEP_ACC_P;
         end
         STEP_ACC_P: begin
            w.acc_op    = ACC_LOAD;
            w.mul_sel   = MUL_KI_INT;
            w.next_step = STEP_ACC_I;
         end
         STEP_ACC_I: begin
            w.acc_op    = ACC_ADD;
            w.next_step = STEP_DIV_WAIT;
         end
         STEP_DIV_WAIT: begin
            w.cond      = COND_WAIT_DIV;
            w.next_step = STEP_DER;
         end
         STEP_DER: begin
            w.der_en    = 1'b1;
            w.next_step = STEP_MUL_D;
         end
         STEP_MUL_D: begin
            w.mul_sel   = MUL_KD_DER;
            w.next_step = STEP_ACC_D;
         end
         STEP_ACC_D: begin
            w.acc_op    = ACC_ADD;
            w.next_step = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.cond      = COND_WAIT_OUT;
            w.emit      = 1'b1;
            w.next_step = STEP_WAIT;
         end
         default: begin
            w.next_step = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/pid_controller_step.sv
// PID controller step with integral clamp, all values signed Q16.16.
// Input channel req_*: one word per sample, tdata = measured value (bits 31:0)
// and elapsed time since the previous sample (bits 63:32, zero counts as one LSB).
// Result channel rsp_*: one word per sample, tdata = saturated drive value.
// Configuration: csr_wr_en writes csr_wdata to register csr_index
// (0 kp, 1 ki, 2 kd, 3 setpoint, 4 integral limit, 5 zero band) at the clock
// edge; write only while no sample is in flight.
// A small microcode program steps a shared 33x33 multiplier, an accumulator
// and a one-bit-per-cycle divider for the derivative term.
// Per sample the program latches the error, starts the divider, updates the
// integral, sums the P and I terms, waits for the 48 divider iterations, adds
// the D term and emits, then takes a new sample. The result sits in an output
// register, so the next sample is accepted while a result still waits; the
// program holds at its last step only if the previous result is not yet taken.
// Reset (synchronous, active high) clears the stored error and integral,
// restores the register defaults and empties the output register.
module pid_controller_step
   import pidc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_wdata,
   // sample input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*DATA_W-1:0]   req_tdata,   // measured [31:0], elapsed_time [63:32]
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata    // drive [31:0]
);

   // Configuration registers
   logic [DATA_W-1:0]  kp_ff, ki_ff, kd_ff, setpoint_ff;
   logic [LIMIT_W-1:0] limit_ff, band_ff;

   // Sequencer
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         ucode;

   // Datapath registers
   logic [DATA_W-1:0] meas_ff, dt_ff;
   logic [DATA_W-1:0] err_ff, err_in;
   logic [DATA_W-1:0] prev_ff;
   logic [DATA_W-1:0] integral_ff, integral_in;
   logic [DATA_W-1:0] der_ff, der_in;
   logic              div_neg_ff;
   logic [63:0]       prod_ff;
   logic signed [49:0] acc_ff, acc_in;
   logic              rsp_tvalid_ff;
   logic [DATA_W-1:0] rsp_tdata_ff, drive_sat;

   // Combinational helpers
   logic               req_fire, out_blocked, emit_fire;
   logic [DATA_W:0]    err_diff, delta;
   logic [DATA_W-1:0]  delta_mag, meas_mag;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] product;
   logic signed [48:0] integ_sum, lim_pos, lim_neg;
   logic signed [49:0] term;
   logic               zero_clear;
   logic [DIV_DIVIDEND_W-1:0] quo;
   div_req_type        div_req;
   div_stat_type       div_stat;

   assign ucode       = ucode_rom(step_ff);
   assign req_tready  = (ucode.cond == COND_WAIT_REQ);
   assign req_fire    = req_tvalid & req_tready;
   assign out_blocked = rsp_tvalid_ff & ~rsp_tready;
   assign emit_fire   = ucode.emit & ~out_blocked;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff       <= '0;
         ki_ff       <= '0;
         kd_ff       <= '0;
         setpoint_ff <= '0;
         limit_ff    <= LIMIT_RESET;
         band_ff     <= BAND_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KP:       kp_ff       <= csr_wdata;
            CSR_KI:       ki_ff       <= csr_wdata;
            CSR_KD:       kd_ff       <= csr_wdata;
            CSR_SETPOINT: setpoint_ff <= csr_wdata;
            CSR_LIMIT:    limit_ff    <= csr_wdata[LIMIT_W-1:0];
            CSR_BAND:     band_ff     <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Next step: hold on a true wait condition, else follow the control word
   always_comb begin
      case (ucode.cond)
         COND_WAIT_REQ: step_in = req_tvalid    ? ucode.next_step : step_ff;
         COND_WAIT_DIV: step_in = div_stat.busy ? step_ff : ucode.next_step;
         COND_WAIT_OUT: step_in = out_blocked   ? step_ff : ucode.next_step;
         default:       step_in = ucode.next_step;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // Error, saturated to 32 bits
   always_comb begin
      err_diff = {setpoint_ff[DATA_W-1], setpoint_ff} - {meas_ff[DATA_W-1], meas_ff};
      if (err_diff[DATA_W] != err_diff[DATA_W-1]) begin
         err_in = err_diff[DATA_W] ? SAT_MIN : SAT_MAX;
      end else begin
         err_in = err_diff[DATA_W-1:0];
      end
   end

   // Error delta for the derivative, split into sign and magnitude
   always_comb begin
      delta     = {err_ff[DATA_W-1], err_ff} - {prev_ff[DATA_W-1], prev_ff};
      delta_mag = delta[DATA_W] ? DATA_W'(-delta) : delta[DATA_W-1:0];
   end

   assign div_req.start    = ucode.div_start;
   assign div_req.dividend = {delta_mag, 16'b0};
   assign div_req.divisor  = dt_ff;

   pidc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   // Shared multiplier, product registered
   always_comb begin
      case (ucode.mul_sel)
         MUL_ERR_DT: begin
            mul_a = $signed({err_ff[DATA_W-1], err_ff});
            mul_b = $signed({1'b0, dt_ff});
         end
         MUL_KP_ERR: begin
            mul_a = $signed({kp_ff[DATA_W-1], kp_ff});
            mul_b = $signed({err_ff[DATA_W-1], err_ff});
         end
         MUL_KI_INT: begin
            mul_a = $signed({ki_ff[DATA_W-1], ki_ff});
            mul_b = $signed({integral_ff[DATA_W-1], integral_ff});
         end
         MUL_KD_DER: begin
            mul_a = $signed({kd_ff[DATA_W-1], kd_ff});
            mul_b = $signed({der_ff[DATA_W-1], der_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = mul_a * mul_b;
   end

   // Integral update: add floor(err*dt / 2^16), clamp, clear near zero
   always_comb begin
      integ_sum  = $signed({{17{integral_ff[DATA_W-1]}}, integral_ff})
                 + $signed({prod_ff[63], prod_ff[63:16]});
      lim_pos    = $signed({18'b0, limit_ff});
      lim_neg    = -lim_pos;
      meas_mag   = meas_ff[DATA_W-1] ? DATA_W'(-meas_ff) : meas_ff;
      zero_clear = (setpoint_ff == '0) && (meas_mag < {1'b0, band_ff});
      if (integ_sum > lim_pos) begin
         integral_in = lim_pos[DATA_W-1:0];
      end else if (integ_sum < lim_neg) begin
         integral_in = lim_neg[DATA_W-1:0];
      end else begin
         integral_in = integ_sum[DATA_W-1:0];
      end
      if (zero_clear) begin
         integral_in = '0;
      end
   end

   // Derivative: sign the quotient and saturate
   always_comb begin
      quo = div_stat.quotient;
      if (!div_neg_ff) begin
         der_in = (|quo[DIV_DIVIDEND_W-1:DATA_W-1]) ? SAT_MAX : quo[DATA_W-1:0];
      end else if ((|quo[DIV_DIVIDEND_W-1:DATA_W]) ||
                   (quo[DATA_W-1] && (|quo[DATA_W-2:0]))) begin
         der_in = SAT_MIN;
      end else begin
         der_in = DATA_W'(-quo[DATA_W-1:0]);
      end
   end

   // Accumulate the floored product terms
   always_comb begin
      term = $signed({{2{prod_ff[63]}}, prod_ff[63:16]});
      case (ucode.acc_op)
         ACC_LOAD: acc_in = term;
         ACC_ADD:  acc_in = acc_ff + term;
         default:  acc_in = acc_ff;
      endcase
   end

   // Drive saturation
   always_comb begin
      if ((&acc_ff[49:31]) || !(|acc_ff[49:31])) begin
         drive_sat = acc_ff[DATA_W-1:0];
      end else begin
         drive_sat = acc_ff[49] ? SAT_MIN : SAT_MAX;
      end
   end

   // Stored controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         integral_ff <= '0;
      end else begin
         if (ucode.prev_en) begin
            prev_ff <= err_ff;
         end
         if (ucode.integ_en) begin
            integral_ff <= integral_in;
         end
      end
   end

   // Working registers of the datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         meas_ff <= req_tdata[DATA_W-1:0];
         dt_ff   <= (req_tdata[2*DATA_W-1:DATA_W] == '0) ? DATA_W'(1)
                                                          : req_tdata[2*DATA_W-1:DATA_W];
      end
      if (ucode.err_en) begin
         err_ff <= err_in;
      end
      if (ucode.div_start) begin
         div_neg_ff <= delta[DATA_W];
      end
      if (ucode.der_en) begin
         der_ff <= der_in;
      end
      prod_ff <= product[63:0];
      acc_ff  <= acc_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_tdata_ff <= drive_sat;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // Divider is idle whenever the program waits for a sample
   a_div_idle_at_wait: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_WAIT) |-> !div_stat.busy)
      else $error("divider busy while waiting for a sample");

   // Derivative is taken only from a finished quotient
   a_der_after_div: assert property (@(posedge clock) disable iff (reset)
      ucode.der_en |-> !div_stat.busy)
      else $error("derivative latched while divider busy");

   // Stored integral stays within the clamp after an update
   a_integral_clamped: assert property (@(posedge clock) disable iff (reset)
      ucode.integ_en |=> ($signed(integral_ff) <= $signed({1'b0, limit_ff}) &&
                          $signed(integral_ff) >= -$signed({1'b0, limit_ff})))
      else $error("integral outside clamp");

   // A result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> $stable(rsp_tdata_ff) || $past(emit_fire) == 1'b0)
      else $error("pending result overwritten");
`endif

endmodule

### hw/rtl/pidc_divider.sv
module pidc_divider
   import pidc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  div_req,
   output div_stat_type div_stat
);

   logic                      busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]      count_ff, count_in;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic [DIV_DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0]         divisor_ff, divisor_in;
   logic [DATA_W:0]           shifted;
   logic                      fits;

   // Restoring division, one quotient bit a cycle
   always_comb begin
      shifted    = {rem_ff, quo_ff[DIV_DIVIDEND_W-1]};
      fits       = (shifted >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIV_STEPS);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DATA_W'(shifted - {1'b0, divisor_ff}) : shifted[DATA_W-1:0];
         quo_in   = {quo_ff[DIV_DIVIDEND_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_stat.busy     = busy_ff;
   assign div_stat.quotient = quo_ff;

endmodule
